// ===== hw/rtl/ttg_pkg.sv =====
// Shared types and constants for the trapezoidal trajectory generator.
`timescale 1ns / 1ps
`default_nettype none
package ttg_pkg;

  typedef enum logic [2:0] {
    PH_ACCEL  = 3'd0,
    PH_CRUISE = 3'd1,
    PH_DECEL  = 3'd2,
    PH_STOP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_MOVE_TIME     = 2'd1,
    REG_HOLD_TIME     = 2'd2,
    REG_ACCEL_LIMIT   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_PREP,
    ST_S_SQ,
    ST_S_DIV,
    ST_S_PEAK,
    ST_S_FIN,
    ST_T_TIME,
    ST_T_MUL1,
    ST_T_MUL2,
    ST_T_MUL3,
    ST_T_FIN,
    ST_OUT
  } state_t;

  // One-hot style command word from controller to datapath.
  typedef struct packed {
    logic load_in;
    logic s_prep;
    logic s_sq;
    logic div_step;
    logic s_peak;
    logic s_fin;
    logic t_time;
    logic t_mul1;
    logic t_mul2;
    logic t_mul3;
    logic t_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic div_done;
    logic tick_active;
    logic tick_moving;
  } dp_sts_t;

  localparam int unsigned DivSteps = 51;

endpackage
`default_nettype wire

// ===== hw/rtl/ttg_ctrl.sv =====
// Controller state machine sequencing start planning and tick updates.
`timescale 1ns / 1ps
`default_nettype none
module ttg_ctrl
  import ttg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_S_PREP;
      ST_S_PREP: state_nxt = sts.is_start ? ST_S_SQ : ST_T_TIME;
      ST_S_SQ:   state_nxt = ST_S_DIV;
      ST_S_DIV:  if (sts.div_done) state_nxt = ST_S_PEAK;
      ST_S_PEAK: state_nxt = ST_S_FIN;
      ST_S_FIN:  state_nxt = ST_OUT;
      ST_T_TIME: begin
        if (sts.tick_active && sts.tick_moving) begin
          state_nxt = ST_T_MUL1;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_T_MUL1: state_nxt = ST_T_MUL2;
      ST_T_MUL2: state_nxt = ST_T_MUL3;
      ST_T_MUL3: state_nxt = ST_T_FIN;
      ST_T_FIN:  state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_S_PREP: cmd.s_prep   = sts.is_start;
      ST_S_SQ:   cmd.s_sq     = 1'b1;
      ST_S_DIV:  cmd.div_step = 1'b1;
      ST_S_PEAK: cmd.s_peak   = 1'b1;
      ST_S_FIN:  cmd.s_fin    = 1'b1;
      ST_T_TIME: cmd.t_time   = 1'b1;
      ST_T_MUL1: cmd.t_mul1   = 1'b1;
      ST_T_MUL2: cmd.t_mul2   = 1'b1;
      ST_T_MUL3: cmd.t_mul3   = 1'b1;
      ST_T_FIN:  cmd.t_fin    = 1'b1;
      ST_OUT:    out_valid    = 1'b1;
      default: ;
    endcase
  end

  // A request is only taken while no other one is in flight.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("double accept");

endmodule
`default_nettype wire

// ===== hw/rtl/ttg_dp.sv =====
// Datapath: planning divider, tick integrator and output registers.
`timescale 1ns / 1ps
`default_nettype none
module ttg_dp
  import ttg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_target_position,
  input  wire logic signed [31:0] in_start_position,
  input  wire dp_cmd_t            cmd,
  output dp_sts_t                 sts,
  output logic signed [31:0]      out_position_setpoint,
  output logic signed [31:0]      out_velocity_setpoint,
  output logic signed [31:0]      out_accel_setpoint,
  output logic [2:0]              out_motion_phase,
  output logic                    out_move_running,
  output logic                    out_plot_running
);

  logic [31:0] sample_period_r, move_time_r, hold_time_r;
  logic [30:0] accel_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= 32'd16777;
      move_time_r     <= 32'd16777216;
      hold_time_r     <= 32'd0;
      accel_limit_r   <= 31'd65536000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
        REG_MOVE_TIME:     move_time_r     <= cfg_data;
        REG_HOLD_TIME:     hold_time_r     <= cfg_data;
        REG_ACCEL_LIMIT:   accel_limit_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Input capture.
  logic               func_r;
  logic signed [31:0] tgt_r, st_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      tgt_r  <= in_target_position;
      st_r   <= in_start_position;
    end
  end

  // Move state.
  logic [31:0]        elapsed_r, blend_r, amag_r, peak_r;
  logic               dirneg_r;
  logic signed [31:0] prev_pos_r, prev_vel_r, final_pos_r;
  logic signed [31:0] pos_r, vel_r, acc_r;
  phase_t             phase_r;
  logic               active_r, plot_r;

  // Planning scratch.
  logic [32:0]  dq_r;
  logic [30:0]  cap_r;
  logic [63:0]  den_r;
  logic [63:0]  q_r;
  logic [64:0]  rem_r;
  logic [6:0]   cnt_r;
  logic         sat_r;

  // Tick scratch.
  logic signed [31:0] a_r;
  logic [63:0]        p1_r, tsq_r, ph_r, pl_r;
  logic [46:0]        hs_r;

  logic signed [33:0] delta;
  assign delta = 34'(tgt_r) - 34'(st_r);

  // The cap 4/5 of the limit is a reciprocal multiplication, exact for 31-bit limits.
  logic [64:0] cap_prod;
  assign cap_prod = 65'(accel_limit_r) * 65'(36'h333333334);

  // Restoring divider: one quotient bit per step, dividend dq shifted in.
  logic [64:0] rem_sh;
  logic        q_bit;
  logic [63:0] q_next;
  logic        dq_bit;
  logic [5:0]  dq_idx;
  assign dq_idx = 6'd32 - cnt_r[5:0];
  assign dq_bit = (cnt_r < 7'd33) ? dq_r[dq_idx] : 1'b0;
  assign rem_sh = {rem_r[63:0], dq_bit};
  assign q_bit  = (rem_sh >= {1'b0, den_r});
  assign q_next = {q_r[62:0], q_bit};
  assign sts.div_done = (cnt_r == 7'(DivSteps + 32)) || sat_r;

  // Tick time and phase decision.
  logic [32:0] tsum;
  logic [31:0] t_new;
  logic [32:0] tf_tc;
  logic [32:0] tf_hold;
  assign tsum    = {1'b0, elapsed_r} + {1'b0, sample_period_r};
  assign t_new   = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
  assign tf_tc   = {1'b0, move_time_r} - {1'b0, blend_r};
  assign tf_hold = {1'b0, move_time_r} + {1'b0, hold_time_r};

  // A move time shortened below the blend time leaves no cruise window.
  phase_t tick_phase;
  always_comb begin
    if (t_new < blend_r)                           tick_phase = PH_ACCEL;
    else if (!tf_tc[32] && ({1'b0, t_new} < tf_tc)) tick_phase = PH_CRUISE;
    else if (t_new <= move_time_r)                 tick_phase = PH_DECEL;
    else if ({1'b0, t_new} <= tf_hold)             tick_phase = PH_STOP;
    else                                           tick_phase = PH_DONE;
  end

  assign sts.is_start    = func_r;
  assign sts.tick_active = active_r;
  assign sts.tick_moving = (tick_phase == PH_ACCEL) || (tick_phase == PH_CRUISE)
                         || (tick_phase == PH_DECEL);

  logic signed [32:0] qa;
  assign qa = dirneg_r ? -$signed({1'b0, amag_r}) : $signed({1'b0, amag_r});

  logic [31:0] abs_a, abs_vp;
  assign abs_a  = a_r[31] ? 32'(-a_r) : a_r;
  assign abs_vp = prev_vel_r[31] ? 32'(-prev_vel_r) : prev_vel_r;

  // Velocity and position updates, evaluated once the products are held.
  logic signed [40:0] dv, dp1, v_new;
  logic signed [47:0] dp2;
  logic signed [40:0] peak_s;
  logic signed [40:0] v_cl;
  logic signed [49:0] q_new;
  logic [63:0]        hs;
  assign dv   = a_r[31] ? -$signed({1'b0, p1_r[63:24]}) : $signed({1'b0, p1_r[63:24]});
  assign hs   = (ph_r + {32'd0, pl_r[63:32]}) >> 17;
  assign dp2  = a_r[31] ? -$signed({1'b0, hs_r}) : $signed({1'b0, hs_r});
  assign dp1  = prev_vel_r[31] ? -$signed({1'b0, tsq_r[63:24]})
                               : $signed({1'b0, tsq_r[63:24]});
  assign v_new  = 41'(prev_vel_r) + dv;
  assign peak_s = $signed({9'b0, peak_r});
  always_comb begin
    v_cl = v_new;
    if (!dirneg_r) begin
      if (v_cl < 0) v_cl = '0;
      if (v_cl > peak_s) v_cl = peak_s;
    end else begin
      if (v_cl < -peak_s) v_cl = -peak_s;
      if (v_cl > 0) v_cl = '0;
    end
  end
  assign q_new = 50'(prev_pos_r) + 50'(dp1) + 50'(dp2);
  logic signed [31:0] q_sat;
  assign q_sat = (q_new > 50'sd2147483647) ? 32'sh7FFFFFFF :
                 (q_new < -50'sd2147483648) ? 32'sh80000000 : q_new[31:0];

  logic [63:0] pk;
  assign pk = 64'(amag_r) * 64'(blend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      blend_r     <= '0;
      amag_r      <= '0;
      peak_r      <= '0;
      dirneg_r    <= 1'b0;
      prev_pos_r  <= '0;
      prev_vel_r  <= '0;
      final_pos_r <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
      phase_r     <= PH_DONE;
      active_r    <= 1'b0;
      plot_r      <= 1'b0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      if (cmd.s_prep) begin
        dq_r     <= delta[33] ? 33'(-delta) : delta[32:0];
        dirneg_r <= delta[33];
        cap_r    <= cap_prod[64:34];
        blend_r  <= move_time_r >> 1;
      end
      if (cmd.s_sq) begin
        den_r <= 64'(move_time_r) * 64'(move_time_r);
        q_r   <= '0;
        rem_r <= '0;
        cnt_r <= '0;
        sat_r <= (dq_r == '0);
      end
      if (cmd.div_step && !sts.div_done) begin
        cnt_r <= cnt_r + 7'd1;
        if (q_bit) rem_r <= rem_sh - {1'b0, den_r};
        else       rem_r <= rem_sh;
        q_r <= q_next;
        if (q_next > {33'd0, cap_r} || den_r == '0) sat_r <= 1'b1;
      end
      if (cmd.s_peak) begin
        if (dq_r == '0)                                   amag_r <= '0;
        else if (sat_r || q_r > {33'd0, cap_r})           amag_r <= {1'b0, cap_r};
        else                                              amag_r <= q_r[31:0];
      end
      if (cmd.s_fin) begin
        peak_r      <= (pk[63:24] > 40'h7FFFFFFF) ? 32'h7FFFFFFF : pk[55:24];
        final_pos_r <= tgt_r;
        prev_pos_r  <= st_r;
        prev_vel_r  <= '0;
        vel_r       <= '0;
        acc_r       <= amag_r;
        phase_r     <= PH_ACCEL;
        active_r    <= 1'b1;
        plot_r      <= 1'b1;
        elapsed_r   <= '0;
      end
      if (cmd.t_time) begin
        if (!active_r) begin
          plot_r <= 1'b0;
        end else begin
          elapsed_r <= t_new;
          phase_r   <= tick_phase;
          case (tick_phase)
            PH_ACCEL:  a_r <= qa[31:0];
            PH_CRUISE: a_r <= '0;
            PH_DECEL:  a_r <= 32'(-qa);
            PH_STOP: begin
              vel_r <= '0;
              pos_r <= final_pos_r;
              acc_r <= '0;
            end
            default:   active_r <= 1'b0;
          endcase
        end
      end
      if (cmd.t_mul1) begin
        p1_r  <= 64'(abs_a) * 64'(sample_period_r);
        tsq_r <= 64'(sample_period_r) * 64'(sample_period_r);
      end
      if (cmd.t_mul2) begin
        ph_r <= 64'(abs_a) * 64'(tsq_r[63:32]);
        pl_r <= 64'(abs_a) * 64'(tsq_r[31:0]);
        tsq_r <= 64'(abs_vp) * 64'(sample_period_r);
      end
      if (cmd.t_mul3) begin
        hs_r <= hs[46:0];
      end
      if (cmd.t_fin) begin
        acc_r      <= a_r;
        prev_vel_r <= v_cl[31:0];
        vel_r      <= v_cl[31:0];
        prev_pos_r <= q_sat;
        pos_r      <= q_sat;
      end
    end
  end

  assign out_position_setpoint = pos_r;
  assign out_velocity_setpoint = vel_r;
  assign out_accel_setpoint    = acc_r;
  assign out_motion_phase      = phase_r;
  assign out_move_running      = active_r;
  assign out_plot_running      = plot_r;

endmodule
`default_nettype wire

// ===== hw/rtl/trapezoidal_trajectory_generator_top.sv =====
// Top level of the trapezoidal trajectory generator.
// A tick request passes through the prep and tick-time states to the output when the
// move is idle, holding or complete, and also through the multiply and finish states
// while it moves. A start runs the prep, square, 83-step bit-serial acceleration
// divider, peak and finish states; the divider ends early when the quotient saturates
// or the distance is zero. One request is in flight at a time; the result holds
// until taken. Synchronous active-low reset zeroes the move state, sets the phase
// to complete and returns the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module trapezoidal_trajectory_generator_top
  import ttg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_target_position,
  input  wire logic signed [31:0] in_start_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_position_setpoint,
  output logic signed [31:0]      out_velocity_setpoint,
  output logic signed [31:0]      out_accel_setpoint,
  output logic [2:0]              out_motion_phase,
  output logic                    out_move_running,
  output logic                    out_plot_running
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ttg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttg_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_func               (in_func),
    .in_target_position    (in_target_position),
    .in_start_position     (in_start_position),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_position_setpoint (out_position_setpoint),
    .out_velocity_setpoint (out_velocity_setpoint),
    .out_accel_setpoint    (out_accel_setpoint),
    .out_motion_phase      (out_motion_phase),
    .out_move_running      (out_move_running),
    .out_plot_running      (out_plot_running)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the trapezoidal trajectory generator top level.
`timescale 1ns / 1ps
module tb
  import ttg_pkg::*;
();

  localparam logic [31:0] OneSec = 32'h0100_0000;
  localparam int CycleLimit = 1000000;

  typedef struct {
    logic        func;
    logic [31:0] tgt;
    logic [31:0] st;
  } move_req_t;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
    logic [2:0]  ph;
    logic        run;
    logic        plot;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic signed [31:0] in_target_position = '0;
  logic signed [31:0] in_start_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_position_setpoint, out_velocity_setpoint, out_accel_setpoint;
  logic [2:0] out_motion_phase;
  logic out_move_running, out_plot_running;

  trapezoidal_trajectory_generator_top uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  move_req_t req_q[$];
  setpoint_t setpoint_q[$];
  int snd_idle = 18;
  int rcv_idle = 69;
  int n_accepted = 0;
  int n_errors = 0;
  int cycles = 0;
  logic in_fire = 1'b0;

  // Register copies and generator state used for prediction.
  logic [31:0] cur_sp = 32'd16777, cur_mt = 32'd16777216, cur_ht = 32'd0;
  logic [30:0] cur_al = 31'd65536000;
  logic [31:0] el_time, bl_time, a_mag, pk_spd;
  logic dir_neg, act_f, plot_f;
  logic signed [31:0] prv_pos, prv_vel, fin_pos, pos_r, vel_r, acc_r;
  phase_t ph_r;

  function automatic longint mul_ts_q24(longint s, logic [31:0] u);
    logic [63:0] m, p;
    m = (s < 0) ? -s : s;
    p = (m * {32'b0, u}) >> 24;
    return (s < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint half_accel_ts2(longint a, logic [31:0] ts);
    logic [127:0] m, p;
    m = (a < 0) ? -a : a;
    p = (m * ts * ts) >> 49;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  task automatic plan_move(logic signed [31:0] tgt, logic signed [31:0] st);
    longint dlt;
    logic [63:0] dq, cap, qc, pk;
    logic [127:0] quo, den;
    dlt = longint'(tgt) - longint'(st);
    dq = (dlt < 0) ? -dlt : dlt;
    cap = ({33'b0, cur_al} * 4) / 5;
    qc = 0;
    den = {96'b0, cur_mt} * {96'b0, cur_mt};
    if (dq != 0) begin
      if (den == 0) begin
        qc = cap;
      end else begin
        quo = ({64'b0, dq} << 50) / den;
        qc = (quo > cap) ? cap : quo[63:0];
      end
    end
    dir_neg = dlt < 0;
    bl_time = cur_mt >> 1;
    pk = (qc * bl_time) >> 24;
    if (pk > 64'h7FFF_FFFF) pk = 64'h7FFF_FFFF;
    a_mag = qc[31:0];
    pk_spd = pk[31:0];
    fin_pos = tgt;
    prv_pos = st;
    prv_vel = 0;
    vel_r = 0;
    acc_r = qc[31:0];
    ph_r = PH_ACCEL;
    act_f = 1'b1;
    plot_f = 1'b1;
    el_time = 0;
  endtask

  task automatic advance_tick();
    logic [32:0] sum;
    longint t, tc, tf, a, qa, v, vp, q;
    if (!act_f) begin
      plot_f = 1'b0;
      return;
    end
    sum = el_time + cur_sp;
    el_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    t = el_time;
    tc = bl_time;
    tf = cur_mt;
    qa = dir_neg ? -longint'(a_mag) : longint'(a_mag);
    if (t < tc) begin
      ph_r = PH_ACCEL;
      a = qa;
    end else if (t < tf - tc) begin
      ph_r = PH_CRUISE;
      a = 0;
    end else if (t <= tf) begin
      ph_r = PH_DECEL;
      a = -qa;
    end else if (t <= tf + longint'(cur_ht)) begin
      ph_r = PH_STOP;
      vel_r = 0;
      pos_r = fin_pos;
      acc_r = 0;
      return;
    end else begin
      ph_r = PH_DONE;
      act_f = 1'b0;
      return;
    end
    acc_r = a[31:0];
    vp = prv_vel;
    v = vp + mul_ts_q24(a, cur_sp);
    if (!dir_neg) begin
      if (v < 0) v = 0;
      if (v > longint'(pk_spd)) v = pk_spd;
    end else begin
      if (v < -longint'(pk_spd)) v = -longint'(pk_spd);
      if (v > 0) v = 0;
    end
    q = longint'(prv_pos) + mul_ts_q24(vp, cur_sp) + half_accel_ts2(a, cur_sp);
    prv_vel = v[31:0];
    vel_r = v[31:0];
    if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
    if (q < -64'sh8000_0000) q = -64'sh8000_0000;
    prv_pos = q[31:0];
    pos_r = q[31:0];
  endtask

  always @(negedge clk) begin
    move_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (req_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        r = req_q.pop_front();
        in_valid <= 1'b1;
        in_func <= r.func;
        in_target_position <= r.tgt;
        in_start_position <= r.st;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so the block backs up into the sender.
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && n_accepted > 300) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= rcv_idle;
    end
  end

  always @(posedge clk) begin
    setpoint_t e, g;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
    in_fire <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      g = '{out_position_setpoint, out_velocity_setpoint, out_accel_setpoint,
            out_motion_phase, out_move_running, out_plot_running};
      if (setpoint_q.size() == 0) begin
        $display("%0t: unexpected result pos=%h", $time, g.pos);
        n_errors++;
      end else begin
        e = setpoint_q.pop_front();
        if (g.pos !== e.pos) begin
          $display("%0t: position exp %h got %h", $time, e.pos, g.pos);
          n_errors++;
        end
        if (g.vel !== e.vel) begin
          $display("%0t: velocity exp %h got %h", $time, e.vel, g.vel);
          n_errors++;
        end
        if (g.acc !== e.acc) begin
          $display("%0t: accel exp %h got %h", $time, e.acc, g.acc);
          n_errors++;
        end
        if (g.ph !== e.ph) begin
          $display("%0t: phase exp %0d got %0d", $time, e.ph, g.ph);
          n_errors++;
        end
        if (g.run !== e.run) begin
          $display("%0t: move_running exp %b got %b", $time, e.run, g.run);
          n_errors++;
        end
        if (g.plot !== e.plot) begin
          $display("%0t: plot_running exp %b got %b", $time, e.plot, g.plot);
          n_errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      n_accepted <= n_accepted + 1;
      if (in_func) plan_move(in_target_position, in_start_position);
      else advance_tick();
      setpoint_q.push_back('{pos_r, vel_r, acc_r, ph_r, act_f, plot_f});
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SAMPLE_PERIOD: cur_sp = val;
      REG_MOVE_TIME:     cur_mt = val;
      REG_HOLD_TIME:     cur_ht = val;
      default:           cur_al = val[30:0];
    endcase
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid || setpoint_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] sp, logic [31:0] mt, logic [31:0] ht,
                           logic [31:0] al);
    wait_drained();
    write_reg(REG_SAMPLE_PERIOD, sp);
    write_reg(REG_MOVE_TIME, mt);
    write_reg(REG_HOLD_TIME, ht);
    write_reg(REG_ACCEL_LIMIT, al);
  endtask

  task automatic push_req(logic func, logic [31:0] tgt, logic [31:0] st);
    req_q.push_back('{func, tgt, st});
  endtask

  // Well-formed moves: a start, then enough ticks to run through the
  // profile and the hold, sometimes cut short by the next start.
  task automatic fill_moves(int count);
    int n, nt, k;
    logic [31:0] st, tgt;
    logic [63:0] span;
    n = 0;
    while (n < count) begin
      st = $urandom;
      k = $urandom_range(99);
      if (k < 50) tgt = $urandom;
      else if (k < 85) tgt = st + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      else tgt = st;
      push_req(1'b1, tgt, st);
      span = ({32'b0, cur_mt} + cur_ht) / cur_sp + 3;
      nt = (span > 50) ? 50 : int'(span);
      if ($urandom_range(9) == 0) nt = $urandom_range(1, nt);
      repeat (nt) push_req(1'b0, $urandom, $urandom);
      n += nt + 1;
    end
  endtask

  initial begin
    logic [31:0] mt, sp;
    el_time = 0; bl_time = 0; a_mag = 0; pk_spd = 0;
    dir_neg = 0; act_f = 0; plot_f = 0;
    prv_pos = 0; prv_vel = 0; fin_pos = 0; pos_r = 0; vel_r = 0; acc_r = 0;
    ph_r = PH_DONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme distances both ways, zero distance, idle ticks.
    push_req(1'b0, 32'h0, 32'h0);
    configure(OneSec >> 3, OneSec, OneSec >> 2, 32'h7FFF_FFFF);
    push_req(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    repeat (13) push_req(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    repeat (3) push_req(1'b0, 32'h0, 32'h0);
    push_req(1'b1, 32'h5, 32'h5);
    repeat (3) push_req(1'b0, 32'h0, 32'h0);
    push_req(1'b1, 32'hFFFF_FFFF, 32'h0);
    push_req(1'b0, 32'h0, 32'h0);

    for (int p = 0; p < 16; p++) begin
      if (p == 5) begin
        snd_idle = 69;
        rcv_idle = 18;
      end else if (p == 11) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      mt = $urandom_range(OneSec >> 4, OneSec << 2);
      sp = mt / $urandom_range(3, 30);
      if (sp == 0) sp = 1;
      case (p)
        0: configure(1, 40, 5, $urandom);
        1: configure(32'hFFFF_FFFF, mt, $urandom_range(0, mt >> 1), $urandom);
        2: configure(32'hFFFF_FFFF / 20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
        3: configure(sp, mt, $urandom_range(0, mt >> 1), 0);
        4: configure(1, 1, 0, 32'h7FFF_FFFF);
        6: configure(sp, mt, 32'hFFFF_FFFF, $urandom);
        8: configure(sp, mt, 0, 32'h7FFF_FFFF);
        default: configure(sp, mt, $urandom_range(0, mt >> 1), $urandom);
      endcase
      fill_moves(95);
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
